/* design/blr_pkg.sv */
package blr_pkg;

	localparam int COORD_BITS_DEF = 13;
	localparam int MAX_STEPS_DEF = 64;
	localparam int CHAN_W = 8;
	localparam int CFG_W = 13;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_W-1:0] ROWS_RESET = 13'd480;
	localparam logic [CFG_W-1:0] COLS_RESET = 13'd640;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_IMAGE_ROWS = 1'b0,
		REG_IMAGE_COLS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] rows;
		logic [CFG_W-1:0] cols;
	} img_cfg_t;

	// width of one line descriptor as packed by the front end
	function automatic int desc_width(int coord_bits, int max_steps);
		return 4 * coord_bits + $clog2(max_steps + 1) + 4 + 3 * CHAN_W;
	endfunction

endpackage

/* design/blr_front.sv */
module blr_front import blr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int MAX_STEPS = MAX_STEPS_DEF,
	localparam int DESC_W = desc_width(COORD_BITS, MAX_STEPS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [COORD_BITS-1:0] start_row,
	input  logic signed [COORD_BITS-1:0] start_col,
	input  logic signed [COORD_BITS-1:0] end_row,
	input  logic signed [COORD_BITS-1:0] end_col,
	input  logic [CHAN_W-1:0]            chan_zero,
	input  logic [CHAN_W-1:0]            chan_one,
	input  logic [CHAN_W-1:0]            chan_two,
	output logic                         q_push,
	output logic [DESC_W-1:0]            q_desc,
	input  logic                         q_full
);

	localparam int C = COORD_BITS;
	localparam int CNT_W = $clog2(MAX_STEPS + 1);

	typedef struct packed {
		logic [C-1:0]      maj;
		logic [C-1:0]      mnr;
		logic [C-1:0]      dmaj;
		logic [C-1:0]      dmin;
		logic              row_major;
		logic              smaj_neg;
		logic              smin_neg;
		logic              trunc;
		logic [CNT_W-1:0]  count;
		logic [CHAN_W-1:0] ch0;
		logic [CHAN_W-1:0] ch1;
		logic [CHAN_W-1:0] ch2;
	} desc_t;

	logic                s1_valid_q;
	logic signed [C-1:0] start_row_s1;
	logic signed [C-1:0] start_col_s1;
	logic signed [C-1:0] end_row_s1;
	logic signed [C-1:0] end_col_s1;
	logic [CHAN_W-1:0]   chan_zero_s1;
	logic [CHAN_W-1:0]   chan_one_s1;
	logic [CHAN_W-1:0]   chan_two_s1;

	logic signed [C:0] dr;
	logic signed [C:0] dc;
	logic [C-1:0]      adr;
	logic [C-1:0]      adc;
	logic              row_major;
	desc_t             desc;
	logic              nonzero;
	logic              drain;

	always_comb begin
		dr = (C+1)'(end_row_s1) - (C+1)'(start_row_s1);
		dc = (C+1)'(end_col_s1) - (C+1)'(start_col_s1);
		adr = dr[C] ? C'(-dr) : C'(dr);
		adc = dc[C] ? C'(-dc) : C'(dc);
		// ties go to the column axis
		row_major = adr > adc;

		desc.maj = row_major ? start_row_s1 : start_col_s1;
		desc.mnr = row_major ? start_col_s1 : start_row_s1;
		desc.dmaj = row_major ? adr : adc;
		desc.dmin = row_major ? adc : adr;
		desc.row_major = row_major;
		desc.smaj_neg = row_major ? dr[C] : dc[C];
		desc.smin_neg = row_major ? dc[C] : dr[C];
		desc.trunc = desc.dmaj > C'(MAX_STEPS);
		desc.count = desc.trunc ? CNT_W'(MAX_STEPS) : CNT_W'(desc.dmaj);
		desc.ch0 = chan_zero_s1;
		desc.ch1 = chan_one_s1;
		desc.ch2 = chan_two_s1;
	end

	// zero-length lines produce nothing and are dropped here
	assign nonzero = |desc.dmaj;
	assign drain = !s1_valid_q || !nonzero || !q_full;
	assign full = !drain;
	assign q_push = s1_valid_q && nonzero && !q_full;
	assign q_desc = desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (drain) begin
			s1_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && drain) begin
			start_row_s1 <= start_row;
			start_col_s1 <= start_col;
			end_row_s1 <= end_row;
			end_col_s1 <= end_col;
			chan_zero_s1 <= chan_zero;
			chan_one_s1 <= chan_one;
			chan_two_s1 <= chan_two;
		end
	end

endmodule

/* design/blr_queue.sv */
module blr_queue import blr_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full = cnt_q == CNT_W'(DEPTH);
	assign empty = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");
`endif

endmodule

/* design/blr_back.sv */
module blr_back import blr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int MAX_STEPS = MAX_STEPS_DEF,
	localparam int DESC_W = desc_width(COORD_BITS, MAX_STEPS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  img_cfg_t                      cfg,
	input  logic [DESC_W-1:0]             q_desc,
	input  logic                          q_empty,
	output logic                          q_pop,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [COORD_BITS-1:0]  pix_row,
	output logic signed [COORD_BITS-1:0]  pix_col,
	output logic [CHAN_W-1:0]             out_chan_zero,
	output logic [CHAN_W-1:0]             out_chan_one,
	output logic [CHAN_W-1:0]             out_chan_two,
	output logic                          in_image,
	output logic                          last_pixel,
	output logic                          truncated
);

	localparam int C = COORD_BITS;
	localparam int CNT_W = $clog2(MAX_STEPS + 1);
	localparam int CMP_W = (C > CFG_W) ? C : CFG_W;

	typedef struct packed {
		logic [C-1:0]      maj;
		logic [C-1:0]      mnr;
		logic [C-1:0]      dmaj;
		logic [C-1:0]      dmin;
		logic              row_major;
		logic              smaj_neg;
		logic              smin_neg;
		logic              trunc;
		logic [CNT_W-1:0]  count;
		logic [CHAN_W-1:0] ch0;
		logic [CHAN_W-1:0] ch1;
		logic [CHAN_W-1:0] ch2;
	} desc_t;

	desc_t d;

	// stepping state
	logic              active_q;
	logic [CNT_W-1:0]  remain_q;
	logic [C-1:0]      maj_q;
	logic [C-1:0]      mnr_q;
	logic [C:0]        err_q;
	logic [C-1:0]      dmaj_q;
	logic [C-1:0]      dmin_q;
	logic              row_major_q;
	logic              smaj_neg_q;
	logic              smin_neg_q;
	logic              trunc_q;
	logic [CHAN_W-1:0] ch0_q;
	logic [CHAN_W-1:0] ch1_q;
	logic [CHAN_W-1:0] ch2_q;

	// result register
	logic              out_valid_q;
	logic [C-1:0]      out_row_q;
	logic [C-1:0]      out_col_q;
	logic [CHAN_W-1:0] out_ch0_q;
	logic [CHAN_W-1:0] out_ch1_q;
	logic [CHAN_W-1:0] out_ch2_q;
	logic              out_in_q;
	logic              out_last_q;
	logic              out_trunc_q;

	logic             step;
	logic             last;
	logic [C-1:0]     row;
	logic [C-1:0]     col;
	logic             pix_in;
	logic [C:0]       err_sum;
	logic             minor_step;

	assign d = q_desc;
	assign q_pop = !active_q && !q_empty;
	assign step = active_q && (!out_valid_q || pop);
	assign last = remain_q == CNT_W'(1);

	always_comb begin
		row = row_major_q ? maj_q : mnr_q;
		col = row_major_q ? mnr_q : maj_q;
		pix_in = !row[C-1] && !col[C-1] &&
			(CMP_W'(row) < CMP_W'(cfg.rows)) && (CMP_W'(col) < CMP_W'(cfg.cols));
		err_sum = err_q + (C+1)'(dmin_q);
		minor_step = err_sum >= (C+1)'(dmaj_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			remain_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				active_q <= 1'b1;
				remain_q <= d.count;
			end else if (step) begin
				remain_q <= remain_q - 1'b1;
				if (last) begin
					active_q <= 1'b0;
				end
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			maj_q <= d.maj;
			mnr_q <= d.mnr;
			err_q <= (C+1)'(d.dmaj >> 1);
			dmaj_q <= d.dmaj;
			dmin_q <= d.dmin;
			row_major_q <= d.row_major;
			smaj_neg_q <= d.smaj_neg;
			smin_neg_q <= d.smin_neg;
			trunc_q <= d.trunc;
			ch0_q <= d.ch0;
			ch1_q <= d.ch1;
			ch2_q <= d.ch2;
		end else if (step) begin
			maj_q <= smaj_neg_q ? maj_q - 1'b1 : maj_q + 1'b1;
			if (minor_step) begin
				mnr_q <= smin_neg_q ? mnr_q - 1'b1 : mnr_q + 1'b1;
				err_q <= err_sum - (C+1)'(dmaj_q);
			end else begin
				err_q <= err_sum;
			end
		end
		if (step) begin
			out_row_q <= row;
			out_col_q <= col;
			out_ch0_q <= ch0_q;
			out_ch1_q <= ch1_q;
			out_ch2_q <= ch2_q;
			out_in_q <= pix_in;
			out_last_q <= last;
			out_trunc_q <= last && trunc_q;
		end
	end

	assign empty = !out_valid_q;
	assign pix_row = out_row_q;
	assign pix_col = out_col_q;
	assign out_chan_zero = out_ch0_q;
	assign out_chan_one = out_ch1_q;
	assign out_chan_two = out_ch2_q;
	assign in_image = out_in_q;
	assign last_pixel = out_last_q;
	assign truncated = out_trunc_q;

`ifndef NO_ASSERTIONS
	a_trunc_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_trunc_q |-> out_last_q)
		else $error("truncated flag off the last pixel");

	a_remain_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> remain_q != '0)
		else $error("active line with no steps left");

	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> err_q < (C+1)'(dmaj_q))
		else $error("error term reached major delta");
`endif

endmodule

/* design/bresenham_line_rasterizer_unit.sv */
// Line rasterizer: one line command in, one pixel request out per step.
// Command side is a queue write port: a request is taken at a clock edge
// with push high and full low; it carries the start and end points and a
// three-channel colour. Result side is a queue read port: while empty is
// low the oldest pixel sits on pix_row/pix_col/out_chan_*/in_image/
// last_pixel/truncated and leaves at an edge with pop high.
// A line of n = max(|dr|,|dc|) steps gives min(n, MAX_STEPS) pixels, the end
// point excluded; zero-length lines give none. The first pixel passes
// the descriptor queue write, the stepper load and the result register
// in that order after the command is taken. The stepper then makes one
// pixel per cycle while pop does not stall it, with a load between lines;
// the stepper is what sets the rate. The front end classifies the next
// command into a two-entry queue meanwhile.
// A stalled pop holds the result register, stops the stepper, then the
// queue fills and full rises. image_rows/image_cols sit on the APB port at
// byte addresses 0 and 4 and set the in_image clip window; write them only
// while idle. Reset clears all queues and in-flight lines and loads 480/640.
module bresenham_line_rasterizer_unit import blr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int MAX_STEPS = MAX_STEPS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// APB configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ADDR_W-1:0]            paddr,
	input  logic [DATA_W-1:0]            pwdata,
	output logic [DATA_W-1:0]            prdata,
	output logic                         pready,
	// command channel
	input  logic                         push,
	output logic                         full,
	input  logic signed [COORD_BITS-1:0] start_row,
	input  logic signed [COORD_BITS-1:0] start_col,
	input  logic signed [COORD_BITS-1:0] end_row,
	input  logic signed [COORD_BITS-1:0] end_col,
	input  logic [CHAN_W-1:0]            chan_zero,
	input  logic [CHAN_W-1:0]            chan_one,
	input  logic [CHAN_W-1:0]            chan_two,
	// pixel channel
	output logic                         empty,
	input  logic                         pop,
	output logic signed [COORD_BITS-1:0] pix_row,
	output logic signed [COORD_BITS-1:0] pix_col,
	output logic [CHAN_W-1:0]            out_chan_zero,
	output logic [CHAN_W-1:0]            out_chan_one,
	output logic [CHAN_W-1:0]            out_chan_two,
	output logic                         in_image,
	output logic                         last_pixel,
	output logic                         truncated
);

	localparam int DESC_W = desc_width(COORD_BITS, MAX_STEPS);

	img_cfg_t          cfg_q;
	reg_idx_t          reg_idx;
	logic              cfg_wr;

	logic              q_push;
	logic [DESC_W-1:0] q_wdata;
	logic              q_full;
	logic              q_pop;
	logic [DESC_W-1:0] q_rdata;
	logic              q_empty;

	// register select is the word address
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows <= ROWS_RESET;
			cfg_q.cols <= COLS_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_IMAGE_ROWS: cfg_q.rows <= pwdata[CFG_W-1:0];
				REG_IMAGE_COLS: cfg_q.cols <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_IMAGE_ROWS: prdata = DATA_W'(cfg_q.rows);
			REG_IMAGE_COLS: prdata = DATA_W'(cfg_q.cols);
			default: prdata = '0;
		endcase
	end

	// front end: takes commands, works out deltas, axis and step count
	blr_front #(
		.COORD_BITS(COORD_BITS),
		.MAX_STEPS(MAX_STEPS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.start_row(start_row),
		.start_col(start_col),
		.end_row(end_row),
		.end_col(end_col),
		.chan_zero(chan_zero),
		.chan_one(chan_one),
		.chan_two(chan_two),
		.q_push(q_push),
		.q_desc(q_wdata),
		.q_full(q_full)
	);

	// line descriptors between the two halves
	blr_queue #(
		.WIDTH(DESC_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(q_wdata),
		.full(q_full),
		.pop(q_pop),
		.pop_data(q_rdata),
		.empty(q_empty)
	);

	// back end: Bresenham stepper and result register
	blr_back #(
		.COORD_BITS(COORD_BITS),
		.MAX_STEPS(MAX_STEPS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_desc(q_rdata),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.empty(empty),
		.pop(pop),
		.pix_row(pix_row),
		.pix_col(pix_col),
		.out_chan_zero(out_chan_zero),
		.out_chan_one(out_chan_one),
		.out_chan_two(out_chan_two),
		.in_image(in_image),
		.last_pixel(last_pixel),
		.truncated(truncated)
	);

endmodule

/* tb/sv/blr_line_checker.sv */
`timescale 1ns / 100ps

// Watches the config port and both queue ports, rasterizes each accepted
// line request itself and checks every popped pixel in order.
module blr_line_checker import blr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int MAX_STEPS = MAX_STEPS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ADDR_W-1:0]            paddr,
	input  logic [DATA_W-1:0]            pwdata,
	input  logic                         pready,
	input  logic                         push,
	input  logic                         full,
	input  logic signed [COORD_BITS-1:0] start_row,
	input  logic signed [COORD_BITS-1:0] start_col,
	input  logic signed [COORD_BITS-1:0] end_row,
	input  logic signed [COORD_BITS-1:0] end_col,
	input  logic [CHAN_W-1:0]            chan_zero,
	input  logic [CHAN_W-1:0]            chan_one,
	input  logic [CHAN_W-1:0]            chan_two,
	input  logic                         empty,
	input  logic                         pop,
	input  logic signed [COORD_BITS-1:0] pix_row,
	input  logic signed [COORD_BITS-1:0] pix_col,
	input  logic [CHAN_W-1:0]            out_chan_zero,
	input  logic [CHAN_W-1:0]            out_chan_one,
	input  logic [CHAN_W-1:0]            out_chan_two,
	input  logic                         in_image,
	input  logic                         last_pixel,
	input  logic                         truncated,
	output int                           mismatch_count,
	output int                           pix_pending,
	output int                           lines_taken,
	output int                           pixels_checked
);

	typedef struct {
		logic signed [COORD_BITS-1:0] row;
		logic signed [COORD_BITS-1:0] col;
		logic [CHAN_W-1:0]            c0;
		logic [CHAN_W-1:0]            c1;
		logic [CHAN_W-1:0]            c2;
		logic                         in_img;
		logic                         last;
		logic                         cut;
	} pixel_t;

	pixel_t     pending_pixels[$];
	img_cfg_t   clip;

	function automatic int step_sign(int v);
		return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
	endfunction

	function automatic void rasterize_line(int r0, int c0, int r1, int c1,
			logic [CHAN_W-1:0] k0, logic [CHAN_W-1:0] k1, logic [CHAN_W-1:0] k2);
		int dr, dc, adr, adc, dmaj, dmin, smaj, smin, maj, mnr, err, steps, row, col;
		bit row_major, cut;
		pixel_t px;
		dr = r1 - r0;
		dc = c1 - c0;
		adr = (dr < 0) ? -dr : dr;
		adc = (dc < 0) ? -dc : dc;
		row_major = adr > adc; // ties go to columns
		dmaj = row_major ? adr : adc;
		dmin = row_major ? adc : adr;
		smaj = row_major ? step_sign(dr) : step_sign(dc);
		smin = row_major ? step_sign(dc) : step_sign(dr);
		cut = dmaj > MAX_STEPS;
		steps = cut ? MAX_STEPS : dmaj;
		maj = row_major ? r0 : c0;
		mnr = row_major ? c0 : r0;
		err = dmaj / 2;
		for (int k = 0; k < steps; k++) begin
			row = row_major ? maj : mnr;
			col = row_major ? mnr : maj;
			px.row = row[COORD_BITS-1:0];
			px.col = col[COORD_BITS-1:0];
			px.c0 = k0;
			px.c1 = k1;
			px.c2 = k2;
			px.in_img = row >= 0 && col >= 0 &&
				row < int'(clip.rows) && col < int'(clip.cols);
			px.last = (k == steps - 1);
			px.cut = px.last && cut;
			pending_pixels.push_back(px);
			maj += smaj;
			err += dmin;
			if (err >= dmaj) begin
				mnr += smin;
				err -= dmaj;
			end
		end
	endfunction

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] MISMATCH %s", $realtime, what);
	endtask

	task automatic check_pixel(input pixel_t want);
		if (pix_row !== want.row)
			flag_mismatch($sformatf("pix_row got %0d want %0d", pix_row, want.row));
		if (pix_col !== want.col)
			flag_mismatch($sformatf("pix_col got %0d want %0d", pix_col, want.col));
		if (out_chan_zero !== want.c0)
			flag_mismatch($sformatf("out_chan_zero got %0h want %0h", out_chan_zero, want.c0));
		if (out_chan_one !== want.c1)
			flag_mismatch($sformatf("out_chan_one got %0h want %0h", out_chan_one, want.c1));
		if (out_chan_two !== want.c2)
			flag_mismatch($sformatf("out_chan_two got %0h want %0h", out_chan_two, want.c2));
		if (in_image !== want.in_img)
			flag_mismatch($sformatf("in_image got %b want %b at %0d,%0d",
				in_image, want.in_img, want.row, want.col));
		if (last_pixel !== want.last)
			flag_mismatch($sformatf("last_pixel got %b want %b", last_pixel, want.last));
		if (truncated !== want.cut)
			flag_mismatch($sformatf("truncated got %b want %b", truncated, want.cut));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip.rows = ROWS_RESET;
			clip.cols = COLS_RESET;
			pending_pixels.delete();
			pix_pending = 0;
		end else begin
			// pop side first: a line taken at this edge cannot show yet
			if (pop && !empty) begin
				if (pending_pixels.size() == 0)
					flag_mismatch($sformatf("unexpected pixel at %0d,%0d", pix_row, pix_col));
				else begin
					check_pixel(pending_pixels.pop_front());
					pixels_checked++;
				end
			end
			if (push && !full) begin
				rasterize_line(int'(start_row), int'(start_col), int'(end_row),
					int'(end_col), chan_zero, chan_one, chan_two);
				lines_taken++;
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[2]))
					REG_IMAGE_ROWS: clip.rows = pwdata[CFG_W-1:0];
					REG_IMAGE_COLS: clip.cols = pwdata[CFG_W-1:0];
					default: ;
				endcase
			end
			pix_pending = pending_pixels.size();
		end
	end

endmodule

/* tb/sv/tb_bresenham_line_rasterizer_unit.sv */
`timescale 1ns / 100ps

// Top level: makes line requests and config writes, paces both queue ports,
// and gives the verdict from the checker's mismatch count.
module tb_bresenham_line_rasterizer_unit;
	import blr_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int COORD_MAX = 2 ** (CB - 1) - 1;
	localparam int COORD_MIN = -(2 ** (CB - 1));
	// long enough for a worst-case line at the step cap to pass the pipeline
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT = 500000;
	localparam int ITEMS_PER_PHASE = 48;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_W-1:0]    paddr = '0;
	logic [DATA_W-1:0]    pwdata = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;
	logic                 push = 1'b0;
	logic                 full;
	logic signed [CB-1:0] start_row = '0;
	logic signed [CB-1:0] start_col = '0;
	logic signed [CB-1:0] end_row = '0;
	logic signed [CB-1:0] end_col = '0;
	logic [CHAN_W-1:0]    chan_zero = '0;
	logic [CHAN_W-1:0]    chan_one = '0;
	logic [CHAN_W-1:0]    chan_two = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic signed [CB-1:0] pix_row;
	logic signed [CB-1:0] pix_col;
	logic [CHAN_W-1:0]    out_chan_zero;
	logic [CHAN_W-1:0]    out_chan_one;
	logic [CHAN_W-1:0]    out_chan_two;
	logic                 in_image;
	logic                 last_pixel;
	logic                 truncated;

	int mismatch_count;
	int pix_pending;
	int lines_taken;
	int pixels_checked;
	int cycle_cnt = 0;
	int send_idle_pct = 0;  // chance per cycle that the sender holds off
	int pop_stall_pct = 0;  // chance per cycle that the receiver stalls
	int rows_now = 480;     // mirror of the clip window, for aiming lines
	int cols_now = 640;
	int phase_cnt = 1;

	bresenham_line_rasterizer_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.push         (push),
		.full         (full),
		.start_row    (start_row),
		.start_col    (start_col),
		.end_row      (end_row),
		.end_col      (end_col),
		.chan_zero    (chan_zero),
		.chan_one     (chan_one),
		.chan_two     (chan_two),
		.empty        (empty),
		.pop          (pop),
		.pix_row      (pix_row),
		.pix_col      (pix_col),
		.out_chan_zero(out_chan_zero),
		.out_chan_one (out_chan_one),
		.out_chan_two (out_chan_two),
		.in_image     (in_image),
		.last_pixel   (last_pixel),
		.truncated    (truncated)
	);

	blr_line_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.push          (push),
		.full          (full),
		.start_row     (start_row),
		.start_col     (start_col),
		.end_row       (end_row),
		.end_col       (end_col),
		.chan_zero     (chan_zero),
		.chan_one      (chan_one),
		.chan_two      (chan_two),
		.empty         (empty),
		.pop           (pop),
		.pix_row       (pix_row),
		.pix_col       (pix_col),
		.out_chan_zero (out_chan_zero),
		.out_chan_one  (out_chan_one),
		.out_chan_two  (out_chan_two),
		.in_image      (in_image),
		.last_pixel    (last_pixel),
		.truncated     (truncated),
		.mismatch_count(mismatch_count),
		.pix_pending   (pix_pending),
		.lines_taken   (lines_taken),
		.pixels_checked(pixels_checked)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// hard stop in case the pixel stream hangs
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver: pop decided per cycle at the falling edge
	always @(negedge clk)
		pop = ($urandom_range(0, 99) >= pop_stall_pct);

	function automatic logic signed [CB-1:0] to_coord(int v);
		if (v > COORD_MAX)
			v = COORD_MAX;
		if (v < COORD_MIN)
			v = COORD_MIN;
		return v[CB-1:0];
	endfunction

	// one line request; holds push until full is low at a rising edge
	task automatic send_line(input int r0, input int c0, input int r1, input int c1,
			input logic [CHAN_W-1:0] k0, input logic [CHAN_W-1:0] k1,
			input logic [CHAN_W-1:0] k2);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			push = 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		push = 1'b1;
		start_row = to_coord(r0);
		start_col = to_coord(c0);
		end_row = to_coord(r1);
		end_col = to_coord(c1);
		chan_zero = k0;
		chan_one = k1;
		chan_two = k2;
		do
			@(posedge clk);
		while (full);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// drop push, wait out every predicted pixel, then cover a zero-length
	// line that may still sit in the front end
	task automatic settle();
		@(negedge clk);
		push = 1'b0;
		while (pix_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// start coordinate aimed at the clip edges half of the time
	function automatic int pick_coord(int lim);
		int off;
		off = int'($urandom_range(0, 24)) - 12;
		case ($urandom_range(0, 3))
			0: return off;
			1: return lim + off;
			2: return int'($urandom_range(0, lim));
			default: return int'($urandom_range(0, 8191)) - 4096;
		endcase
	endfunction

	task automatic random_line();
		int r0, c0, r1, c1, len, minor, pick;
		r0 = int'(to_coord(pick_coord(rows_now)));
		c0 = int'(to_coord(pick_coord(cols_now)));
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			// zero length
			r1 = r0;
			c1 = c0;
		end else if (pick < 20) begin
			// end point anywhere, mostly cut at MAX_STEPS
			r1 = int'($urandom_range(0, 8191)) - 4096;
			c1 = int'($urandom_range(0, 8191)) - 4096;
		end else if (pick < 35) begin
			// lengths around the step cap
			len = $urandom_range(MAX_STEPS_DEF - 4, MAX_STEPS_DEF + 6);
			minor = $urandom_range(0, len);
			if ($urandom_range(0, 1)) len = -len;
			if ($urandom_range(0, 1)) minor = -minor;
			if ($urandom_range(0, 1)) begin
				r1 = r0 + len;
				c1 = c0 + minor;
			end else begin
				r1 = r0 + minor;
				c1 = c0 + len;
			end
		end else begin
			r1 = r0 + int'($urandom_range(0, 24)) - 12;
			c1 = c0 + int'($urandom_range(0, 24)) - 12;
		end
		send_line(r0, c0, r1, c1, CHAN_W'($urandom), CHAN_W'($urandom),
			CHAN_W'($urandom));
	endtask

	task automatic run_phase(input logic [DATA_W-1:0] rows_val,
			input logic [DATA_W-1:0] cols_val, input int idle_pct, input int stall_pct);
		settle();
		write_reg(REG_IMAGE_ROWS, rows_val);
		write_reg(REG_IMAGE_COLS, cols_val);
		rows_now = int'(rows_val[CFG_W-1:0]);
		cols_now = int'(cols_val[CFG_W-1:0]);
		send_idle_pct = idle_pct;
		pop_stall_pct = stall_pct;
		phase_cnt++;
		repeat (ITEMS_PER_PHASE) random_line();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed lines against the reset window 480 x 640
		send_line(10, 10, 10, 10, 8'h00, 8'h00, 8'h00);           // zero length
		send_line(0, 0, 0, 5, 8'hFF, 8'hFF, 8'hFF);               // +col
		send_line(0, 5, 0, 0, 8'hAA, 8'h55, 8'hAA);               // -col
		send_line(0, 0, 5, 0, 8'h55, 8'hAA, 8'h55);               // +row, row major
		send_line(5, 0, 0, 0, 8'h01, 8'h80, 8'h7F);               // -row
		send_line(0, 0, 4, 4, 8'h12, 8'h34, 8'h56);               // tie goes to cols
		send_line(4, 4, 0, 0, 8'h9A, 8'hBC, 8'hDE);
		send_line(0, 4, 4, 0, 8'h0F, 8'hF0, 8'h3C);
		send_line(4, 0, 0, 4, 8'hC3, 8'h5A, 8'hA5);
		send_line(0, 0, 7, 3, 8'h11, 8'h22, 8'h33);               // row major with steps
		send_line(0, 0, 3, 7, 8'h44, 8'h55, 8'h66);
		send_line(0, 0, 5, 10, 8'h77, 8'h88, 8'h99);              // error hits exactly
		send_line(-3, -2, 3, 2, 8'hAB, 8'hCD, 8'hEF);             // enters from top-left
		send_line(478, 638, 482, 642, 8'hFE, 8'hDC, 8'hBA);       // leaves bottom-right
		send_line(0, 0, 0, MAX_STEPS_DEF, 8'h10, 8'h20, 8'h30);   // exactly at the cap
		send_line(0, 0, MAX_STEPS_DEF + 1, 0, 8'h40, 8'h50, 8'h60); // one over, cut
		send_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 8'h00, 8'hFF, 8'h00);
		send_line(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 8'hFF, 8'h00, 8'hFF);
		send_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 8'h5A, 8'h5A, 8'h5A);
		send_line(0, 0, 1, 0, 8'h03, 8'h06, 8'h09);               // single pixel
		send_line(0, 0, 0, -1, 8'hF3, 8'hF6, 8'hF9);              // single pixel, heading off image
		send_line(100, 100, 137, 110, 8'h81, 8'h42, 8'h24);

		// clip settings from full range down to empty window, with pacing mixes
		run_phase(32'd4096, 32'd4096, 0, 0);
		run_phase(32'd1, 32'd1, 50, 0);
		run_phase(32'd0, 32'd640, 0, 50);
		run_phase(32'hFFFF_FFFF, 32'hFFFF_E000, 26, 26);          // 8191 and 0 after masking
		run_phase($urandom_range(1, 4096), $urandom_range(1, 4096), 0, 0);
		run_phase(32'd480, 32'd640, 26, 26);

		settle();
		$display("covered %0d line requests and %0d pixels over %0d clip windows,",
			lines_taken, pixels_checked, phase_cnt);
		$display("with sender gaps and receiver stalls at 0, 26 and 50 percent");
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* sim.f */
design/blr_pkg.sv
design/blr_front.sv
design/blr_queue.sv
design/blr_back.sv
design/bresenham_line_rasterizer_unit.sv
tb/sv/blr_line_checker.sv
tb/sv/tb_bresenham_line_rasterizer_unit.sv
